// ===== rtl/core/yucdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yucdm_pkg
// Shared types and constants of the yaw unwrap and crossing delay meter.
// ----------------------------------------------------------------------------
package yucdm_pkg;

	localparam int QUARTER = 16384;
	localparam int SUM_W = 23;
	// kept delays; sets the depth of the delay store and the width of its fill count
	localparam int DELAY_WINDOW = 90;

	// config register indexes
	localparam logic REG_FALLING   = 1'b0;
	localparam logic REG_MAX_DELAY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // latch input, unwrap, write stores
		logic scan_init;  // reset scan accumulators
		logic scan_step;  // fold one display/crossing entry
		logic decide;     // crossing detection, delay update, result load
		logic evict_rd;   // read evicted delay entry
	} yucdm_cmd_t;

	typedef struct packed {
		logic scan_last;  // current scan entry is the last one
	} yucdm_sts_t;

endpackage : yucdm_pkg
`default_nettype wire

// ===== rtl/core/yucdm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yucdm_ctrl
// Sequencer: accept, scan the windows entry by entry, decide, present result.
// ----------------------------------------------------------------------------
module yucdm_ctrl
	import yucdm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output yucdm_cmd_t      cmd,
	input  wire yucdm_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_SCAN, ST_EVICT, ST_DECIDE
	} state_t;

	state_t state_q;
	logic   out_free;

	// result register free, or emptied by a transfer this cycle
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_LOAD:   cmd.scan_init = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_EVICT:  cmd.evict_rd = 1'b1;
			ST_DECIDE: cmd.decide = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_LOAD;
				ST_LOAD:   state_q <= ST_SCAN;
				ST_SCAN:   if (sts.scan_last) state_q <= ST_EVICT;
				ST_EVICT:  state_q <= ST_DECIDE;
				ST_DECIDE: if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
			if (cmd.decide) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

endmodule : yucdm_ctrl
`default_nettype wire

// ===== rtl/core/yucdm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yucdm_dp
// Unwrap, window stores, min/max scan, crossing and delay bookkeeping.
// ----------------------------------------------------------------------------
module yucdm_dp
	import yucdm_pkg::*;
#(
	parameter int DISPLAY_WINDOW = 160,
	parameter int CROSS_WINDOW   = 90,
	parameter int MIN_HISTORY    = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire yucdm_cmd_t         cmd,
	output yucdm_sts_t              sts,
	input  wire logic               falling_direction,
	input  wire logic [15:0]        max_delay_ms,
	input  wire logic signed [15:0] current_angle,
	input  wire logic signed [15:0] target_angle,
	input  wire logic [31:0]        time_ms,
	output logic signed [31:0]      unwrapped_current,
	output logic signed [31:0]      unwrapped_target,
	output logic signed [31:0]      window_min,
	output logic signed [31:0]      window_max,
	output logic                    target_crossed,
	output logic                    delay_recorded,
	output logic [15:0]             delay_ms,
	output logic [SUM_W-1:0]        delay_sum,
	output logic [6:0]              delay_count
);

	localparam int DW = $clog2(DISPLAY_WINDOW + 1);
	localparam int DA = (DISPLAY_WINDOW > 1) ? $clog2(DISPLAY_WINDOW) : 1;
	localparam int CW = $clog2(CROSS_WINDOW + 1);
	localparam int CA = (CROSS_WINDOW > 1) ? $clog2(CROSS_WINDOW) : 1;
	localparam int LW = $clog2(DELAY_WINDOW + 1);
	localparam int LA = (DELAY_WINDOW > 1) ? $clog2(DELAY_WINDOW) : 1;
	localparam int SW = (DW > CW) ? DW : CW;

	logic signed [31:0] disp_cur_mem [DISPLAY_WINDOW];
	logic signed [31:0] disp_tgt_mem [DISPLAY_WINDOW];
	logic signed [31:0] cross_mem [CROSS_WINDOW];
	logic [15:0]        delay_mem [DELAY_WINDOW];

	logic signed [15:0] prev_cur_q, prev_tgt_q, cur_turns_q, tgt_turns_q;
	logic signed [31:0] prev_ucur_q, prev_utgt_q;
	logic signed [31:0] ucur_q, utgt_q;
	logic [31:0]        time_q, cross_time_q;
	logic               cross_valid_q;
	logic [DW-1:0]      disp_fill_q;
	logic [DA-1:0]      disp_wr_q;
	logic [CW-1:0]      cross_fill_q;
	logic [CA-1:0]      cross_wr_q;
	logic [LW-1:0]      delay_fill_q;
	logic [LA-1:0]      delay_wr_q;
	logic [SW-1:0]      scan_q;
	logic               rd_ok_s1, rd_cv_s1, rd_z_s1;
	logic signed [31:0] rd_a_s1, rd_b_s1, rd_t_s1;
	logic signed [31:0] fa, fb;
	logic signed [31:0] wmin_q, wmax_q;
	logic signed [31:0] tmin_q, tmax_q;
	logic               first_q;
	logic               z0_q;      // display entry 0 still holds its reset zero
	logic [15:0]        evict_q;

	// decision
	logic signed [32:0] twice_mid;
	logic               tx, cx, dec_rec, cv_next;
	logic [31:0]        dly, tstart;

	// unwrap
	function automatic logic signed [15:0] next_turns(logic signed [15:0] ang,
			logic signed [15:0] prv, logic signed [15:0] t);
		logic signed [15:0] r;
		r = t;
		if (ang < -16'sd16384 && prv > 16'sd16384) begin
			if (t != 16'sh7fff) r = t + 16'sd1;
		end else if (ang > 16'sd16384 && prv < -16'sd16384) begin
			if (t != 16'sh8000) r = t - 16'sd1;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] make_u(logic signed [15:0] t,
			logic signed [15:0] ang);
		logic signed [32:0] u;
		u = {t[15], t, 16'h0000} + 33'(ang);
		if (u < -33'sd2147483648) u = -33'sd2147483648;
		return u[31:0];
	endfunction

	logic signed [15:0] nct, ntt;
	logic signed [31:0] ucur_c, utgt_c;
	assign nct = next_turns(current_angle, prev_cur_q, cur_turns_q);
	assign ntt = next_turns(target_angle, prev_tgt_q, tgt_turns_q);
	assign ucur_c = make_u(nct, current_angle);
	assign utgt_c = make_u(ntt, target_angle);

	// scan
	logic sc_d, sc_c;
	assign sc_d = (scan_q < SW'(disp_fill_q));
	assign sc_c = (scan_q < SW'(cross_fill_q));
	assign sts.scan_last = (scan_q + SW'(1) >= SW'(disp_fill_q))
		&& (scan_q + SW'(1) >= SW'(cross_fill_q));

	// entry 0 reads as zero until first overwritten
	assign fa = rd_z_s1 ? 32'sd0 : rd_a_s1;
	assign fb = rd_z_s1 ? 32'sd0 : rd_b_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			disp_cur_mem[disp_wr_q]  <= ucur_c;
			disp_tgt_mem[disp_wr_q]  <= utgt_c;
			cross_mem[cross_wr_q]    <= utgt_c;
		end
		rd_a_s1 <= disp_cur_mem[DA'(scan_q)];
		rd_b_s1 <= disp_tgt_mem[DA'(scan_q)];
		rd_t_s1 <= cross_mem[CA'(scan_q)];
		rd_z_s1 <= z0_q && (scan_q == '0);
		if (cmd.evict_rd) evict_q <= delay_mem[delay_wr_q];
		if (cmd.decide && dec_rec) delay_mem[delay_wr_q] <= dly[15:0];
	end

	function automatic logic crossed_f(logic signed [31:0] p, logic signed [31:0] n,
			logic signed [32:0] tm, logic fall);
		logic bb, an;
		bb = ($signed({p, 1'b0}) < tm);
		an = ($signed({n, 1'b0}) >= tm);
		return fall ? (!bb && !an) : (bb && an);
	endfunction
	assign twice_mid = 33'(tmin_q) + 33'(tmax_q);
	always_comb begin
		tx = (cross_fill_q > CW'(MIN_HISTORY))
			&& crossed_f(prev_utgt_q, utgt_q, twice_mid, falling_direction);
		cx = (cross_fill_q > CW'(MIN_HISTORY))
			&& crossed_f(prev_ucur_q, ucur_q, twice_mid, falling_direction);
		cv_next = tx | cross_valid_q;
		tstart  = tx ? time_q : cross_time_q;
		dly     = time_q - tstart;
		dec_rec = cx && cv_next && (dly < {16'h0, max_delay_ms});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cur_q <= '0; prev_tgt_q <= '0; cur_turns_q <= '0; tgt_turns_q <= '0;
			prev_ucur_q <= '0; prev_utgt_q <= '0; cross_time_q <= '0;
			cross_valid_q <= 1'b0;
			disp_fill_q <= DW'(1); disp_wr_q <= DA'(1 % DISPLAY_WINDOW);
			cross_fill_q <= '0; cross_wr_q <= '0;
			delay_fill_q <= '0; delay_wr_q <= '0; delay_sum <= '0;
			rd_ok_s1 <= 1'b0; rd_cv_s1 <= 1'b0; first_q <= 1'b1; z0_q <= 1'b1;
		end else begin
			rd_ok_s1 <= cmd.scan_step & sc_d;
			rd_cv_s1 <= cmd.scan_step & sc_c;
			if (cmd.load) begin
				cur_turns_q <= nct; tgt_turns_q <= ntt;
				prev_cur_q <= current_angle; prev_tgt_q <= target_angle;
				if (disp_wr_q == '0) z0_q <= 1'b0;
				disp_wr_q <= (disp_wr_q == DA'(DISPLAY_WINDOW - 1)) ? '0 : disp_wr_q + DA'(1);
				if (disp_fill_q < DW'(DISPLAY_WINDOW)) disp_fill_q <= disp_fill_q + DW'(1);
				cross_wr_q <= (cross_wr_q == CA'(CROSS_WINDOW - 1)) ? '0 : cross_wr_q + CA'(1);
				if (cross_fill_q < CW'(CROSS_WINDOW)) cross_fill_q <= cross_fill_q + CW'(1);
			end
			if (cmd.scan_init) first_q <= 1'b1;
			else if (rd_cv_s1) first_q <= 1'b0;
			if (cmd.decide) begin
				prev_ucur_q <= ucur_q;
				prev_utgt_q <= utgt_q;
				if (tx) cross_time_q <= time_q;
				cross_valid_q <= cv_next & ~dec_rec;
				if (dec_rec) begin
					if (delay_fill_q == LW'(DELAY_WINDOW))
						delay_sum <= delay_sum - SUM_W'(evict_q) + SUM_W'(dly[15:0]);
					else begin
						delay_fill_q <= delay_fill_q + LW'(1);
						delay_sum <= delay_sum + SUM_W'(dly[15:0]);
					end
					delay_wr_q <= (delay_wr_q == LA'(DELAY_WINDOW - 1)) ? '0
						: delay_wr_q + LA'(1);
				end
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ucur_q <= ucur_c;
			utgt_q <= utgt_c;
			time_q <= time_ms;
		end
		if (cmd.scan_init) scan_q <= '0;
		else if (cmd.scan_step) scan_q <= scan_q + SW'(1);
		if (cmd.scan_init) begin
			wmin_q <= 32'sh7fffffff;
			wmax_q <= 32'sh80000000;
		end else if (rd_ok_s1) begin
			if (fa < wmin_q || fb < wmin_q)
				wmin_q <= (fa < fb) ? fa : fb;
			if (fa > wmax_q || fb > wmax_q)
				wmax_q <= (fa > fb) ? fa : fb;
		end
		if (rd_cv_s1) begin
			if (first_q || rd_t_s1 < tmin_q) tmin_q <= rd_t_s1;
			if (first_q || rd_t_s1 > tmax_q) tmax_q <= rd_t_s1;
		end
		if (cmd.decide) begin
			unwrapped_current <= ucur_q;
			unwrapped_target  <= utgt_q;
			window_min <= wmin_q;
			window_max <= wmax_q;
			target_crossed <= tx;
			delay_recorded <= dec_rec;
			delay_ms <= dec_rec ? dly[15:0] : 16'h0000;
		end
	end

	assign delay_count = 7'(delay_fill_q);

endmodule : yucdm_dp
`default_nettype wire

// ===== rtl/core/yaw_unwrap_crossing_delay_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaw_unwrap_crossing_delay_meter_top
// Yaw unwrap, window extremes and target-to-actual crossing delay meter.
// ----------------------------------------------------------------------------
// One sample at a time: a transfer on the input channel starts a scan that
// reads one entry of each window store per cycle, over as many entries as the
// display window fill after the sample (2 up to DISPLAY_WINDOW); the next input
// is taken once the decide step has loaded the result. The result sits in
// its own output register, so the next sample is taken and scanned while it
// waits; only the final decide step holds until that register is transferred
// out. The delay window length is a fixed package constant. Write config
// registers only while no sample is in flight.
module yaw_unwrap_crossing_delay_meter_top
	import yucdm_pkg::*;
#(
	parameter int DISPLAY_WINDOW = 160,
	parameter int CROSS_WINDOW   = 90,
	parameter int MIN_HISTORY    = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] current_angle,
	input  wire logic signed [15:0] target_angle,
	input  wire logic [31:0]        time_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      unwrapped_current,
	output logic signed [31:0]      unwrapped_target,
	output logic signed [31:0]      window_min,
	output logic signed [31:0]      window_max,
	output logic                    target_crossed,
	output logic                    delay_recorded,
	output logic [15:0]             delay_ms,
	output logic [SUM_W-1:0]        delay_sum,
	output logic [6:0]              delay_count
);

	logic        falling_q;
	logic [15:0] max_delay_q;
	yucdm_cmd_t  cmd;
	yucdm_sts_t  sts;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			falling_q   <= 1'b0;
			max_delay_q <= 16'd500;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FALLING) falling_q <= cfg_data[0];
			else if (cfg_index == REG_MAX_DELAY) max_delay_q <= cfg_data;
		end
	end

	yucdm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
	);

	yucdm_dp #(
		.DISPLAY_WINDOW(DISPLAY_WINDOW), .CROSS_WINDOW(CROSS_WINDOW),
		.MIN_HISTORY(MIN_HISTORY)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.falling_direction(falling_q), .max_delay_ms(max_delay_q),
		.current_angle, .target_angle, .time_ms,
		.unwrapped_current, .unwrapped_target, .window_min, .window_max,
		.target_crossed, .delay_recorded, .delay_ms, .delay_sum, .delay_count
	);

endmodule : yaw_unwrap_crossing_delay_meter_top
`default_nettype wire

// ===== rtl/core/yucdm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yucdm_checker
// Port-level checks of the meter, bound to the top level.
// ----------------------------------------------------------------------------
module yucdm_checker
	import yucdm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       delay_recorded,
	input wire logic [15:0] delay_ms,
	input wire logic [6:0] delay_count
);
	// one sample in flight: input stalls right after a transfer
	a_in_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("second input taken");
	// count never exceeds window size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		delay_count <= 7'(DELAY_WINDOW)) else $error("delay count overflow");
	// no delay value without record
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !delay_recorded) |-> delay_ms == 16'h0000)
		else $error("delay without record");
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	// stalled payload does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(delay_ms) && $stable(delay_recorded)
		&& $stable(delay_count))) else $error("stalled result changed");
endmodule : yucdm_checker

bind yaw_unwrap_crossing_delay_meter_top yucdm_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.delay_recorded, .delay_ms, .delay_count
);
`default_nettype wire

// ===== tb/yaw_unwrap_crossing_delay_meter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_unwrap_crossing_delay_meter_top_test
// Self-checking bench for the yaw unwrap and crossing delay meter. A short
// table of hand-picked samples runs first, then waveform, spin, noise and
// boundary segments under several settings of direction and delay limit. Every
// result is compared field by field against an in-bench model of the meter.
// ----------------------------------------------------------------------------
module yaw_unwrap_crossing_delay_meter_top_test;
	import yucdm_pkg::*;

	localparam int DISP_N  = 160;
	localparam int CROSS_N = 90;
	localparam int HIST_N  = 30;
	localparam int DELAY_N = 90;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int SETTLE_CYCLES = 400;   // well beyond one full window scan
	localparam int EXP_DEPTH     = 8;     // results outstanding at most two
	localparam int ROW_N         = 10;

	// one sample result as the meter reports it
	typedef struct {
		int         ucur;
		int         utgt;
		int         wmin;
		int         wmax;
		bit         tcross;
		bit         recorded;
		bit [15:0]  dly;
		bit [22:0]  sum;
		bit [6:0]   cnt;
	} meter_result_t;

	// directed table row; has_exp marks rows whose unwrap/extremes are typed in
	typedef struct {
		logic signed [15:0] cur;
		logic signed [15:0] tgt;
		bit [31:0]          tm;
		bit                 has_exp;
		int                 ucur;
		int                 utgt;
		int                 wmin;
		int                 wmax;
	} sample_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic                    cfg_index;
	logic [15:0]             cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [15:0]      current_angle;
	logic signed [15:0]      target_angle;
	logic [31:0]             time_ms;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [31:0]      unwrapped_current;
	logic signed [31:0]      unwrapped_target;
	logic signed [31:0]      window_min;
	logic signed [31:0]      window_max;
	logic                    target_crossed;
	logic                    delay_recorded;
	logic [15:0]             delay_ms;
	logic [SUM_W-1:0]        delay_sum;
	logic [6:0]              delay_count;

	yaw_unwrap_crossing_delay_meter_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.current_angle(current_angle), .target_angle(target_angle), .time_ms(time_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.unwrapped_current(unwrapped_current), .unwrapped_target(unwrapped_target),
		.window_min(window_min), .window_max(window_max),
		.target_crossed(target_crossed), .delay_recorded(delay_recorded),
		.delay_ms(delay_ms), .delay_sum(delay_sum), .delay_count(delay_count)
	);

	// ------------------------------------------------------------------
	// Meter model state
	// ------------------------------------------------------------------
	bit        falling_cfg;
	bit [15:0] limit_cfg;
	int        prev_cur_ang, prev_tgt_ang;
	int        cur_turns, tgt_turns;
	int        disp_cur [DISP_N];
	int        disp_tgt [DISP_N];
	int        disp_fill, disp_wr;
	int        cross_tgt [CROSS_N];
	int        cross_fill, cross_wr;
	int        prev_ucur, prev_utgt;
	bit [31:0] cross_time;
	bit        cross_armed;
	bit [15:0] delay_hist [DELAY_N];
	int        delay_fill, delay_wr;
	bit [22:0] delay_total;

	// expected results in acceptance order, a ring with running indexes
	meter_result_t expected_results [EXP_DEPTH];
	int            exp_wr, exp_rd;
	int            errors;
	int            results_seen, crossings_seen, delays_seen, items_sent;
	bit            sender_done;
	int            burst_left;

	// turn counting with saturation; jumps across the half turn count a turn
	function automatic int unwrap_angle(int a, int p, inout int turns);
		longint u;
		if (a < -QUARTER && p > QUARTER) begin
			if (turns < 32767) turns++;
		end else if (a > QUARTER && p < -QUARTER) begin
			if (turns > -32768) turns--;
		end
		u = longint'(turns) * 65536 + a;
		if (u < -64'sd2147483648) u = -64'sd2147483648;
		if (u > 64'sd2147483647) u = 64'sd2147483647;
		return int'(u);
	endfunction

	// midrange crossing in the configured direction, midrange kept doubled
	function automatic bit midrange_crossed(int p, int n, longint twice_mid);
		bit below_before, at_or_above;
		below_before = longint'(p) * 2 < twice_mid;
		at_or_above = longint'(n) * 2 >= twice_mid;
		if (falling_cfg) return !below_before && !at_or_above;
		return below_before && at_or_above;
	endfunction

	task automatic reset_meter_model();
		falling_cfg = 1'b0;
		limit_cfg = 16'd500;
		prev_cur_ang = 0; prev_tgt_ang = 0;
		cur_turns = 0; tgt_turns = 0;
		foreach (disp_cur[i]) begin
			disp_cur[i] = 0; disp_tgt[i] = 0;
		end
		disp_fill = 1; disp_wr = 1;
		foreach (cross_tgt[i]) cross_tgt[i] = 0;
		cross_fill = 0; cross_wr = 0;
		prev_ucur = 0; prev_utgt = 0;
		cross_time = '0; cross_armed = 1'b0;
		foreach (delay_hist[i]) delay_hist[i] = '0;
		delay_fill = 0; delay_wr = 0; delay_total = '0;
	endtask

	task automatic predict_sample(input logic signed [15:0] ca, input logic signed [15:0] ta,
			input bit [31:0] tm, output meter_result_t r);
		int cur, tgt, tmin, tmax;
		bit [31:0] d;
		cur = ca;
		tgt = ta;
		r.tcross = 1'b0; r.recorded = 1'b0; r.dly = '0;
		r.ucur = unwrap_angle(cur, prev_cur_ang, cur_turns);
		r.utgt = unwrap_angle(tgt, prev_tgt_ang, tgt_turns);

		disp_cur[disp_wr] = r.ucur;
		disp_tgt[disp_wr] = r.utgt;
		disp_wr = (disp_wr + 1) % DISP_N;
		if (disp_fill < DISP_N) disp_fill++;
		r.wmin = disp_cur[0];
		r.wmax = disp_cur[0];
		for (int i = 0; i < disp_fill; i++) begin
			if (disp_cur[i] < r.wmin) r.wmin = disp_cur[i];
			if (disp_cur[i] > r.wmax) r.wmax = disp_cur[i];
			if (disp_tgt[i] < r.wmin) r.wmin = disp_tgt[i];
			if (disp_tgt[i] > r.wmax) r.wmax = disp_tgt[i];
		end

		cross_tgt[cross_wr] = r.utgt;
		cross_wr = (cross_wr + 1) % CROSS_N;
		if (cross_fill < CROSS_N) cross_fill++;
		if (cross_fill > HIST_N) begin
			tmin = cross_tgt[0];
			tmax = tmin;
			for (int i = 0; i < cross_fill; i++) begin
				if (cross_tgt[i] < tmin) tmin = cross_tgt[i];
				if (cross_tgt[i] > tmax) tmax = cross_tgt[i];
			end
			// target start is stamped first, so a same-sample actual gives 0
			if (midrange_crossed(prev_utgt, r.utgt, longint'(tmin) + tmax)) begin
				cross_time = tm;
				cross_armed = 1'b1;
				r.tcross = 1'b1;
			end
			if (midrange_crossed(prev_ucur, r.ucur, longint'(tmin) + tmax) && cross_armed) begin
				d = tm - cross_time;
				if (d < {16'd0, limit_cfg}) begin
					r.dly = d[15:0];
					r.recorded = 1'b1;
					cross_armed = 1'b0;
					if (delay_fill == DELAY_N) delay_total = delay_total - delay_hist[delay_wr];
					else delay_fill++;
					delay_hist[delay_wr] = d[15:0];
					delay_total = delay_total + d[15:0];
					delay_wr = (delay_wr + 1) % DELAY_N;
				end
			end
		end

		prev_cur_ang = cur; prev_tgt_ang = tgt;
		prev_ucur = r.ucur; prev_utgt = r.utgt;
		r.sum = delay_total;
		r.cnt = delay_fill[6:0];
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("timeout at %0t", $time);
		$display("yaw_unwrap_crossing_delay_meter_top_test: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: the stall pattern switches to a random mode at regular
	// intervals, so there are stretches of no stall, light and heavy random
	// stall, and a fixed periodic one.
	// ------------------------------------------------------------------
	initial begin : result_monitor
		int cyc;
		int mode;
		meter_result_t e;
		out_stall = 1'b0;
		cyc = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (target_crossed) crossings_seen++;
				if (delay_recorded) delays_seen++;
				if (exp_wr == exp_rd) begin
					errors++;
					$display("%0t: result transfer with nothing expected", $time);
				end else begin
					e = expected_results[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (unwrapped_current !== e.ucur) begin
						errors++;
						$display("%0t: unwrapped_current exp %0d got %0d", $time, e.ucur,
							unwrapped_current);
					end
					if (unwrapped_target !== e.utgt) begin
						errors++;
						$display("%0t: unwrapped_target exp %0d got %0d", $time, e.utgt,
							unwrapped_target);
					end
					if (window_min !== e.wmin) begin
						errors++;
						$display("%0t: window_min exp %0d got %0d", $time, e.wmin, window_min);
					end
					if (window_max !== e.wmax) begin
						errors++;
						$display("%0t: window_max exp %0d got %0d", $time, e.wmax, window_max);
					end
					if (target_crossed !== e.tcross) begin
						errors++;
						$display("%0t: target_crossed exp %0b got %0b", $time, e.tcross,
							target_crossed);
					end
					if (delay_recorded !== e.recorded) begin
						errors++;
						$display("%0t: delay_recorded exp %0b got %0b", $time, e.recorded,
							delay_recorded);
					end
					if (delay_ms !== e.dly) begin
						errors++;
						$display("%0t: delay_ms exp %0d got %0d", $time, e.dly, delay_ms);
					end
					if (delay_sum !== e.sum) begin
						errors++;
						$display("%0t: delay_sum exp %0d got %0d", $time, e.sum, delay_sum);
					end
					if (delay_count !== e.cnt) begin
						errors++;
						$display("%0t: delay_count exp %0d got %0d", $time, e.cnt, delay_count);
					end
				end
			end
			cyc++;
			if (cyc % 100 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				2: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_stall <= (cyc % 7 < 3);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------

	// one transfer; the model is advanced at acceptance, and bursts end
	// with a random gap of idle cycles
	task automatic send_sample(input logic signed [15:0] ca, input logic signed [15:0] ta,
			input bit [31:0] tm, output meter_result_t r);
		in_valid <= 1'b1;
		current_angle <= ca;
		target_angle <= ta;
		time_ms <= tm;
		do @(posedge clk); while (in_stall);
		predict_sample(ca, ta, tm, r);
		expected_results[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
		items_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// drain: all expected results back, then a full scan time of quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input bit idx, input bit [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FALLING) falling_cfg = val[0];
		else limit_cfg = val;
	endtask

	// random waveform material: triangle target, actual lagging behind it
	bit [31:0] clock_ms;
	int        lag_hist [8];

	task automatic run_segment();
		int kind, len, amp, offs, period, lag, step_c, step_t, ph, half, tv, ac, tc;
		meter_result_t r;
		logic signed [15:0] picks [6];
		picks[0] = -16'sd32768; picks[1] = 16'sd32767; picks[2] = 16'sd0;
		picks[3] = 16'sd16384; picks[4] = -16'sd16384; picks[5] = 16'sd16385;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 15) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
		if (kind <= 6) begin
			len = $urandom_range(40, 120);
			amp = $urandom_range(300, 15000);
			offs = $signed($urandom_range(0, 65535)) - 32768;
			period = $urandom_range(4, 40);
			lag = $urandom_range(0, 7);
			half = period / 2;
			ph = $urandom_range(0, period - 1);
			for (int k = 0; k < len; k++) begin
				tv = (ph % period < half) ? (-amp + 2 * amp * (ph % period) / half)
					: (amp - 2 * amp * (ph % period - half) / (period - half));
				tv = tv + offs;
				for (int j = 7; j > 0; j--) lag_hist[j] = lag_hist[j - 1];
				lag_hist[0] = tv;
				clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30));
				send_sample(16'(lag_hist[lag]), 16'(tv), clock_ms, r);
				ph++;
			end
		end else if (kind == 7) begin
			// steady spin of both series, counting turns either way
			len = $urandom_range(20, 60);
			step_c = $urandom_range(3000, 20000) * (($urandom_range(0, 1) == 0) ? 1 : -1);
			step_t = $urandom_range(3000, 20000) * (($urandom_range(0, 1) == 0) ? 1 : -1);
			ac = $urandom_range(0, 65535);
			tc = $urandom_range(0, 65535);
			for (int k = 0; k < len; k++) begin
				ac += step_c;
				tc += step_t;
				clock_ms = clock_ms + $urandom_range(1, 5);
				send_sample(16'(ac), 16'(tc), clock_ms, r);
			end
		end else if (kind == 8) begin
			// full-range noise, timestamps anywhere including backwards
			repeat ($urandom_range(5, 20)) begin
				clock_ms = $urandom();
				send_sample(16'($urandom()), 16'($urandom()), clock_ms, r);
			end
		end else begin
			// quarter and half turn boundary values
			repeat ($urandom_range(5, 20)) begin
				clock_ms = clock_ms + $urandom_range(0, 3);
				send_sample(picks[$urandom_range(0, 5)], picks[$urandom_range(0, 5)], clock_ms, r);
			end
		end
	endtask

	sample_row_t directed_rows [ROW_N];

	initial begin : stimulus
		meter_result_t r;
		sample_row_t row;
		int phase_end;

		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_FALLING; cfg_data = '0;
		in_valid = 1'b0; current_angle = '0; target_angle = '0; time_ms = '0;
		errors = 0; results_seen = 0; crossings_seen = 0; delays_seen = 0; items_sent = 0;
		exp_wr = 0; exp_rd = 0;
		sender_done = 1'b0; burst_left = 0; clock_ms = '0;
		foreach (lag_hist[i]) lag_hist[i] = 0;
		reset_meter_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the window holds a single zero
		directed_rows[0] = '{16'sd0, 16'sd0, 32'd0, 1'b1, 0, 0, 0, 0};
		// positive and negative extremes, no turn counted from zero
		directed_rows[1] = '{16'sd32767, -16'sd32768, 32'd1, 1'b1,
			32767, -32768, -32768, 32767};
		// half-turn jumps each way: a turn is gained and one lost
		directed_rows[2] = '{-16'sd32768, 16'sd32767, 32'd2, 1'b1,
			32768, -32769, -32769, 32768};
		directed_rows[3] = '{16'sd16384, -16'sd16384, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0};
		directed_rows[4] = '{-16'sd16385, 16'sd16385, 32'h8000_0000, 1'b0, 0, 0, 0, 0};
		directed_rows[5] = '{16'sd16385, -16'sd16385, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0};
		directed_rows[6] = '{-16'sd1, 16'sd1, 32'h5555_5555, 1'b0, 0, 0, 0, 0};
		directed_rows[7] = '{16'sh5555, -16'sh5556, 32'hAAAA_AAAA, 1'b0, 0, 0, 0, 0};
		directed_rows[8] = '{-16'sh5556, 16'sh5555, 32'd0, 1'b0, 0, 0, 0, 0};
		directed_rows[9] = '{16'sd0, 16'sd0, 32'd3, 1'b0, 0, 0, 0, 0};

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_sample(row.cur, row.tgt, row.tm, r);
			if (row.has_exp && (r.ucur != row.ucur || r.utgt != row.utgt ||
					r.wmin != row.wmin || r.wmax != row.wmax)) begin
				errors++;
				$display("%0t: table row %0d exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time, i,
					row.ucur, row.utgt, row.wmin, row.wmax, r.ucur, r.utgt, r.wmin, r.wmax);
			end
		end

		// random phases, each under its own setting of direction and limit;
		// the first keeps the reset values
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				wait_drained();
				case (ph)
					1: begin
						write_register(REG_FALLING, 16'd1);
						write_register(REG_MAX_DELAY, 16'hFFFF);
					end
					2: begin
						write_register(REG_FALLING, 16'd0);
						write_register(REG_MAX_DELAY, 16'd1);
					end
					3: begin
						write_register(REG_FALLING, 16'd1);
						write_register(REG_MAX_DELAY, 16'd0);
					end
					default: begin
						write_register(REG_FALLING, 16'($urandom_range(0, 1)));
						write_register(REG_MAX_DELAY, 16'($urandom_range(30, 400)));
					end
				endcase
			end
			phase_end = items_sent + RANDOM_ITEMS / 5;
			while (items_sent < phase_end) run_segment();
		end

		sender_done = 1'b1;
		wait_drained();
		$display("%0d samples checked, %0d target crossings, %0d delays recorded",
			results_seen, crossings_seen, delays_seen);
		$display("both directions, delay limits 0, 1, 500, 65535 and random");
		if (errors == 0) begin
			$display("yaw_unwrap_crossing_delay_meter_top_test: clean");
		end else begin
			$display("yaw_unwrap_crossing_delay_meter_top_test: errors");
		end
		$finish;
	end

endmodule

// ===== yaw_unwrap_crossing_delay_meter_top.f =====
rtl/core/yucdm_pkg.sv
rtl/core/yucdm_ctrl.sv
rtl/core/yucdm_dp.sv
rtl/core/yaw_unwrap_crossing_delay_meter_top.sv
rtl/core/yucdm_checker.sv
tb/yaw_unwrap_crossing_delay_meter_top_test.sv
